// ===== sv/per_source_fixed_window_rate_limiter_macros.svh =====
// assertion macros for the per-source rate limiter checker
`ifndef PER_SOURCE_FIXED_WINDOW_RATE_LIMITER_MACROS_SVH
`define PER_SOURCE_FIXED_WINDOW_RATE_LIMITER_MACROS_SVH

// same-cycle implication, off while reset is high
`define PSWRL_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rate limiter check failed");

// next-cycle implication, off while reset is high
`define PSWRL_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rate limiter check failed");

`endif

// ===== sv/pswrl_pkg.sv =====
// shared types and constants for the per-source rate limiter
package pswrl_pkg;

   localparam int TABLE_ENTRIES_DEFAULT = 256;

   localparam int ADDR_W  = 32;
   localparam int TIME_W  = 32;
   localparam int CFG_W   = 16;
   localparam int COUNT_W = 16;

   localparam int CSR_INDEX_W = 2;

   localparam logic [CSR_INDEX_W-1:0] CSR_WINDOW_SECONDS = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_REQUESTS   = 2'd1;

   localparam logic [CFG_W-1:0]   WINDOW_RESET  = 16'd10;
   localparam logic [CFG_W-1:0]   MAX_RESET     = 16'd120;
   localparam logic [COUNT_W-1:0] COUNT_CEILING = 16'hFFFF;

   typedef struct packed {
      logic               valid;
      logic [ADDR_W-1:0]  address;
      logic [TIME_W-1:0]  win_base;
      logic [COUNT_W-1:0] count;
   } entry_type;

endpackage

// ===== sv/per_source_fixed_window_rate_limiter.sv =====
// per-source fixed-window rate limiter: table scan, update and verdict
//
// One request (source address, time in seconds) goes in when start is high and busy is
// low; one allow/deny verdict comes back on rsp_allow with rsp_valid high for a single
// cycle, and the receiver cannot stall it. The table sits in one memory with a write port
// and a registered read port, and is scanned one entry per cycle through that read port;
// a request ends its scan at the first entry that holds its source, or at the last entry
// when the source is new. busy drops in the verdict cycle, so the next request may be
// taken there. After reset the block sweeps the table once to clear the valid marks,
// holding busy high until the sweep is done; configuration writes are taken at any time,
// but should only be made while the block is idle.
module per_source_fixed_window_rate_limiter #(
   parameter int TABLE_ENTRIES = pswrl_pkg::TABLE_ENTRIES_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [pswrl_pkg::ADDR_W-1:0]       req_source_address,
   input  logic [pswrl_pkg::TIME_W-1:0]       req_now_seconds,
   output logic                               rsp_valid,
   output logic                               rsp_allow,
   input  logic                               csr_we,
   input  logic [pswrl_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [pswrl_pkg::CFG_W-1:0]        csr_wdata
);
   import pswrl_pkg::*;

   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_FETCH,
      ST_SCAN
   } state_type;

   entry_type mem [TABLE_ENTRIES];
   entry_type rd_data_ff;

   state_type          state_ff, state_in;
   logic [ADDR_W-1:0]  req_addr_ff, req_addr_in;
   logic [TIME_W-1:0]  req_now_ff, req_now_in;
   logic [IDX_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [IDX_W-1:0]   eval_ptr_ff, eval_ptr_in;
   logic               empty_found_ff, empty_found_in;
   logic [IDX_W-1:0]   empty_slot_ff, empty_slot_in;
   logic               expired_found_ff, expired_found_in;
   logic [IDX_W-1:0]   expired_slot_ff, expired_slot_in;
   logic [CFG_W-1:0]   window_ff, window_in;
   logic [CFG_W-1:0]   max_ff, max_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_allow_ff, rsp_allow_in;

   logic               mem_we;
   logic [IDX_W-1:0]   mem_waddr;
   entry_type          mem_wdata;

   logic [TIME_W-1:0]  elapsed;
   logic               expired;
   logic               hit;
   logic               at_last;
   logic [COUNT_W-1:0] count_inc;
   logic               accept;

   assign accept    = start && (state_ff == ST_IDLE);
   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_allow = rsp_allow_ff;

   // the shared compare unit: one entry per cycle
   assign elapsed   = req_now_ff - rd_data_ff.win_base;
   assign expired   = (elapsed >= TIME_W'(window_ff));
   assign hit       = rd_data_ff.valid && (rd_data_ff.address == req_addr_ff);
   assign at_last   = (eval_ptr_ff == LAST_IDX);
   assign count_inc = (rd_data_ff.count == COUNT_CEILING) ? rd_data_ff.count
                                                          : rd_data_ff.count + 16'd1;

   always_comb begin
      state_in         = state_ff;
      req_addr_in      = req_addr_ff;
      req_now_in       = req_now_ff;
      rd_ptr_in        = rd_ptr_ff;
      eval_ptr_in      = eval_ptr_ff;
      empty_found_in   = empty_found_ff;
      empty_slot_in    = empty_slot_ff;
      expired_found_in = expired_found_ff;
      expired_slot_in  = expired_slot_ff;
      window_in        = window_ff;
      max_in           = max_ff;
      rsp_valid_in     = 1'b0;
      rsp_allow_in     = rsp_allow_ff;
      mem_we           = 1'b0;
      mem_waddr        = eval_ptr_ff;
      mem_wdata        = '0;

      if (csr_we) begin
         case (csr_index)
            CSR_WINDOW_SECONDS: window_in = csr_wdata;
            CSR_MAX_REQUESTS:   max_in    = csr_wdata;
            default:            ;
         endcase
      end

      case (state_ff)
         ST_CLEAR: begin
            mem_we      = 1'b1;
            eval_ptr_in = at_last ? '0 : eval_ptr_ff + IDX_W'(1);
            if (at_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               req_addr_in      = req_source_address;
               req_now_in       = req_now_seconds;
               rd_ptr_in        = '0;
               empty_found_in   = 1'b0;
               expired_found_in = 1'b0;
               state_in         = ST_FETCH;
            end
         end
         ST_FETCH: begin
            eval_ptr_in = rd_ptr_ff;
            rd_ptr_in   = (rd_ptr_ff == LAST_IDX) ? '0 : rd_ptr_ff + IDX_W'(1);
            state_in    = ST_SCAN;
         end
         ST_SCAN: begin
            eval_ptr_in = rd_ptr_ff;
            rd_ptr_in   = (rd_ptr_ff == LAST_IDX) ? '0 : rd_ptr_ff + IDX_W'(1);
            if (hit) begin
               mem_we               = 1'b1;
               mem_wdata.valid      = 1'b1;
               mem_wdata.address    = req_addr_ff;
               rsp_valid_in         = 1'b1;
               state_in             = ST_IDLE;
               if (expired) begin
                  // window ran out: restart it
                  mem_wdata.win_base = req_now_ff;
                  mem_wdata.count    = COUNT_W'(1);
                  rsp_allow_in       = 1'b1;
               end else begin
                  mem_wdata.win_base = rd_data_ff.win_base;
                  mem_wdata.count    = count_inc;
                  rsp_allow_in       = (count_inc <= max_ff);
               end
            end else begin
               if (!rd_data_ff.valid && !empty_found_ff) begin
                  empty_found_in = 1'b1;
                  empty_slot_in  = eval_ptr_ff;
               end
               if (rd_data_ff.valid && expired && !expired_found_ff) begin
                  expired_found_in = 1'b1;
                  expired_slot_in  = eval_ptr_ff;
               end
               if (at_last) begin
                  // new source: first empty entry, else first expired, else untracked
                  mem_wdata.valid    = 1'b1;
                  mem_wdata.address  = req_addr_ff;
                  mem_wdata.win_base = req_now_ff;
                  mem_wdata.count    = COUNT_W'(1);
                  if (empty_found_ff) begin
                     mem_we    = 1'b1;
                     mem_waddr = empty_slot_ff;
                  end else if (!rd_data_ff.valid) begin
                     mem_we    = 1'b1;
                     mem_waddr = eval_ptr_ff;
                  end else if (expired_found_ff) begin
                     mem_we    = 1'b1;
                     mem_waddr = expired_slot_ff;
                  end else if (expired) begin
                     mem_we    = 1'b1;
                     mem_waddr = eval_ptr_ff;
                  end
                  rsp_valid_in = 1'b1;
                  rsp_allow_in = 1'b1;
                  state_in     = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_CLEAR;
         eval_ptr_ff      <= '0;
         rd_ptr_ff        <= '0;
         empty_found_ff   <= 1'b0;
         expired_found_ff <= 1'b0;
         window_ff        <= WINDOW_RESET;
         max_ff           <= MAX_RESET;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         eval_ptr_ff      <= eval_ptr_in;
         rd_ptr_ff        <= rd_ptr_in;
         empty_found_ff   <= empty_found_in;
         expired_found_ff <= expired_found_in;
         window_ff        <= window_in;
         max_ff           <= max_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
      req_addr_ff     <= req_addr_in;
      req_now_ff      <= req_now_in;
      empty_slot_ff   <= empty_slot_in;
      expired_slot_ff <= expired_slot_in;
      rsp_allow_ff    <= rsp_allow_in;
   end

endmodule

// ===== sv/pswrl_checker.sv =====
// port-level checks for the per-source rate limiter, bound to the top level
`include "per_source_fixed_window_rate_limiter_macros.svh"

module pswrl_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid
);

   // a verdict strobe lasts one cycle
   `PSWRL_ASSERT_NEXT(a_rsp_one_cycle, clock, reset, rsp_valid, !rsp_valid)

   // an accepted item keeps the block busy
   `PSWRL_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)

   // no verdict right after an item is taken
   `PSWRL_ASSERT_NEXT(a_no_early_rsp, clock, reset, start && !busy, !rsp_valid)

   // the block is free again while its verdict is shown
   `PSWRL_ASSERT_NOW(a_rsp_idle, clock, reset, rsp_valid, !busy)

endmodule

bind per_source_fixed_window_rate_limiter pswrl_checker u_pswrl_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid)
);
